/* design/clb_pkg.sv */
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types, constants and helpers for the cell list binner.
// ----------------------------------------------------------------------------
`default_nettype none

package clb_pkg;

    localparam int GRID_DIM_MAX  = 8;
    localparam int CELL_CAPACITY = 32;
    localparam int ATOM_LIMIT    = 4096;

    localparam int CIDX_W    = $clog2(GRID_DIM_MAX);
    localparam int CELL_W    = 3 * CIDX_W;
    localparam int NUM_CELLS = 1 << CELL_W;
    localparam int SLOT_W    = $clog2(CELL_CAPACITY);
    localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);
    localparam int ID_W      = $clog2(ATOM_LIMIT);
    localparam int IDX_W     = $clog2(ATOM_LIMIT + 1);
    localparam int POS_W     = 24;
    localparam int DIM_W     = 4;
    localparam int THR_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 3'd6;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_BIN    = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic [ID_W-1:0]  atom_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]   old_atom_id;
        logic [IDX_W-1:0]  new_index;
        logic [CIDX_W-1:0] cell_x;
        logic [CIDX_W-1:0] cell_y;
        logic [CIDX_W-1:0] cell_z;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  max_count;
        logic              cell_full;
        logic              over_threshold;
        logic              drain_done;
    } t_res;

    typedef struct packed {
        logic [POS_W-1:0] inv_x;
        logic [POS_W-1:0] inv_y;
        logic [POS_W-1:0] inv_z;
        logic [DIM_W-1:0] cells_x;
        logic [DIM_W-1:0] cells_y;
        logic [DIM_W-1:0] cells_z;
        logic [THR_W-1:0] thresh;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   atom_id;
        logic [CIDX_W-1:0] cx;
        logic [CIDX_W-1:0] cy;
        logic [CIDX_W-1:0] cz;
    } t_cmd;

    // Highest cell index in use along one axis: zero means one cell,
    // anything above the grid saturates.
    function automatic logic [CIDX_W-1:0] dim_last(input logic [DIM_W-1:0] r);
        logic [CIDX_W-1:0] v;
        if (r == '0) begin
            v = '0;
        end else if (r > DIM_W'(GRID_DIM_MAX)) begin
            v = CIDX_W'(GRID_DIM_MAX - 1);
        end else begin
            v = CIDX_W'(r - 1'b1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/cell_list_binner.sv */
// ----------------------------------------------------------------------------
// cell_list_binner
// Counting-sort binner: bins atoms into a 3-D cell grid and drains them back
// in cell order, x outermost and z innermost.
// ----------------------------------------------------------------------------
// Path: an item passes the front's two registers and the command queue. The
//   back end takes one command at a time: a bin runs read, write and emit, a
//   status only emits, a drain reads and checks each cell it steps over, and
//   a clear writes one count entry per cycle through the count memory's single write port.
// Reset: synchronous, active low; afterwards a clearing pass runs over the
//   count memory with full held high. Configuration writes are taken
//   throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_list_binner import clb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item input, queue style
    input  wire logic                 push,
    output logic                      full,
    input  wire t_item                i_item,
    // result output, queue style
    output logic                      empty,
    input  wire logic                 pop,
    output t_res                      o_result,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [POS_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic init, q_full, q_valid, q_pop, cmd_valid;
    t_cmd cmd, q_data;

    // Always ready: registers are only to be written while the block is idle; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    // Hold the configuration registers; write the indexed one on each valid configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_x   <= '0;
            r_cfg.inv_y   <= '0;
            r_cfg.inv_z   <= '0;
            r_cfg.cells_x <= DIM_W'(1);
            r_cfg.cells_y <= DIM_W'(1);
            r_cfg.cells_z <= DIM_W'(1);
            r_cfg.thresh  <= THR_W'(CELL_CAPACITY);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_X:   r_cfg.inv_x   <= i_cfg_data;
                CFG_INV_Y:   r_cfg.inv_y   <= i_cfg_data;
                CFG_INV_Z:   r_cfg.inv_z   <= i_cfg_data;
                CFG_CELLS_X: r_cfg.cells_x <= i_cfg_data[DIM_W-1:0];
                CFG_CELLS_Y: r_cfg.cells_y <= i_cfg_data[DIM_W-1:0];
                CFG_CELLS_Z: r_cfg.cells_z <= i_cfg_data[DIM_W-1:0];
                CFG_THRESH:  r_cfg.thresh  <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: register the item, scale the three coordinates, clamp to cells.
    clb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .i_hold      (init),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Decouple the front from the back so each stalls on its own.
    clb_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back: run the command against the count and slot memories and hold
    // the result in the output register until it is popped.
    clb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_init    (init),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

/* design/clb_ram.sv */
// ----------------------------------------------------------------------------
// clb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/clb_front.sv */
// ----------------------------------------------------------------------------
// clb_front
// Accept items, scale positions and clamp them to cell indices.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_front import clb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_hold,
    input  wire logic  i_q_full,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    logic             r_s1_v;
    t_item            r_s1;
    logic             r_s2_v;
    t_op              r_s2_op;
    logic [ID_W-1:0]  r_s2_id;
    logic [POS_W-1:0] r_px, r_py, r_pz;

    logic [2*POS_W-1:0] prod_x, prod_y, prod_z;
    logic [CIDX_W-1:0]  lim_x, lim_y, lim_z;
    logic s2_free, s1_mv, acc;

    assign s2_free = !r_s2_v || !i_q_full;
    assign s1_mv   = r_s1_v && s2_free;
    assign o_full  = i_hold || (r_s1_v && !s2_free);
    assign acc     = i_push && !o_full;

    assign prod_x = (2*POS_W)'(r_s1.pos_x) * (2*POS_W)'(i_cfg.inv_x);
    assign prod_y = (2*POS_W)'(r_s1.pos_y) * (2*POS_W)'(i_cfg.inv_y);
    assign prod_z = (2*POS_W)'(r_s1.pos_z) * (2*POS_W)'(i_cfg.inv_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= acc || (r_s1_v && !s1_mv);
            r_s2_v <= s1_mv || (r_s2_v && i_q_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= i_item;
        end
        if (s1_mv) begin
            r_s2_op <= r_s1.operation;
            r_s2_id <= r_s1.atom_id;
            r_px    <= prod_x[2*POS_W-1:POS_W];
            r_py    <= prod_y[2*POS_W-1:POS_W];
            r_pz    <= prod_z[2*POS_W-1:POS_W];
        end
    end

    // Clamp each scaled coordinate to the last cell in use.
    always_comb begin
        lim_x = dim_last(i_cfg.cells_x);
        lim_y = dim_last(i_cfg.cells_y);
        lim_z = dim_last(i_cfg.cells_z);
        o_cmd.op      = r_s2_op;
        o_cmd.atom_id = r_s2_id;
        o_cmd.cx = (r_px > POS_W'(lim_x)) ? lim_x : r_px[CIDX_W-1:0];
        o_cmd.cy = (r_py > POS_W'(lim_y)) ? lim_y : r_py[CIDX_W-1:0];
        o_cmd.cz = (r_pz > POS_W'(lim_z)) ? lim_z : r_pz[CIDX_W-1:0];
    end

    assign o_cmd_valid = r_s2_v;

endmodule

`default_nettype wire

/* design/clb_fifo.sv */
// ----------------------------------------------------------------------------
// clb_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_fifo import clb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data
);

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/clb_back.sv */
// ----------------------------------------------------------------------------
// clb_back
// Carry out clear, bin, drain and status commands on the cell memories.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_back import clb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_data,
    output logic      o_q_pop,
    output logic      o_init,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_result
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_BIN_RD, S_BIN_WR,
        S_DR_RD, S_DR_CHK, S_DR_OUT, S_EMIT
    } t_state;

    t_state             r_state;
    logic [CELL_W-1:0]  r_clr_addr;
    t_cmd               r_cmd;
    logic [CNT_W-1:0]   r_max;
    logic [CELL_W-1:0]  r_dcell;
    logic [SLOT_W-1:0]  r_dslot;
    logic [IDX_W-1:0]   r_didx;
    logic               r_dover;
    t_res               r_pend;
    t_res               r_out;
    logic               r_out_v;

    logic [CELL_W-1:0]        cmd_cell;
    logic                     cnt_we;
    logic [CELL_W-1:0]        cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
    logic                     slot_we;
    logic [CELL_W+SLOT_W-1:0] slot_waddr, slot_raddr;
    logic [ID_W-1:0]          slot_rdata;
    logic [CNT_W-1:0]         cnt_inc, new_max;
    logic [CIDX_W-1:0]        dx, dy, dz;
    logic                     in_range, hit, out_free;

    assign cmd_cell   = {r_cmd.cx, r_cmd.cy, r_cmd.cz};
    assign cnt_raddr  = (r_state == S_BIN_RD) ? cmd_cell : r_dcell;
    assign slot_raddr = {r_dcell, r_dslot};
    assign slot_waddr = {cmd_cell, cnt_rdata[SLOT_W-1:0]};
    assign cnt_inc    = cnt_rdata + 1'b1;
    assign new_max    = (cnt_inc > r_max) ? cnt_inc : r_max;

    assign dx = r_dcell[CELL_W-1:2*CIDX_W];
    assign dy = r_dcell[2*CIDX_W-1:CIDX_W];
    assign dz = r_dcell[CIDX_W-1:0];
    assign in_range = (dx <= dim_last(i_cfg.cells_x)) && (dy <= dim_last(i_cfg.cells_y))
                   && (dz <= dim_last(i_cfg.cells_z));
    assign hit = in_range && (CNT_W'(r_dslot) < cnt_rdata);

    assign out_free = !r_out_v || i_pop;
    assign o_empty  = !r_out_v;
    assign o_result = r_out;
    assign o_init   = (r_state == S_INIT);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_clr_addr;
        cnt_wdata = '0;
        slot_we   = 1'b0;
        unique case (r_state)
            S_INIT, S_CLR: begin
                cnt_we = 1'b1;
            end
            S_BIN_WR: begin
                cnt_we    = (cnt_rdata < CNT_W'(CELL_CAPACITY));
                slot_we   = cnt_we;
                cnt_waddr = cmd_cell;
                cnt_wdata = cnt_inc;
            end
            default: begin
            end
        endcase
    end

    clb_ram #(.W(CNT_W), .D(NUM_CELLS)) u_count (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    clb_ram #(.W(ID_W), .D(NUM_CELLS * CELL_CAPACITY)) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_cmd.atom_id),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_clr_addr <= '0;
            r_max      <= '0;
            r_dcell    <= '0;
            r_dslot    <= '0;
            r_didx     <= '0;
            r_dover    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CELL_W'(NUM_CELLS - 1)) begin
                        r_clr_addr <= '0;
                        r_max      <= '0;
                        r_dcell    <= '0;
                        r_dslot    <= '0;
                        r_didx     <= '0;
                        r_dover    <= 1'b0;
                        r_pend     <= '0;
                        r_pend.over_threshold <= (i_cfg.thresh == '0);
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_EMIT;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd  <= i_q_data;
                        r_pend <= '0;
                        r_pend.max_count      <= r_max;
                        r_pend.over_threshold <= (THR_W'(r_max) >= i_cfg.thresh);
                        case (i_q_data.op)
                            OP_CLEAR:  r_state <= S_CLR;
                            OP_BIN:    r_state <= S_BIN_RD;
                            OP_DRAIN: begin
                                if (r_dover) begin
                                    r_pend.drain_done <= 1'b1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_DR_RD;
                                end
                            end
                            default:   r_state <= S_EMIT;
                        endcase
                    end
                end
                S_BIN_RD: begin
                    r_state <= S_BIN_WR;
                end
                S_BIN_WR: begin
                    r_pend.old_atom_id <= r_cmd.atom_id;
                    r_pend.cell_x <= r_cmd.cx;
                    r_pend.cell_y <= r_cmd.cy;
                    r_pend.cell_z <= r_cmd.cz;
                    if (cnt_we) begin
                        r_pend.slot      <= cnt_rdata[SLOT_W-1:0];
                        r_pend.max_count <= new_max;
                        r_pend.over_threshold <= (THR_W'(new_max) >= i_cfg.thresh);
                        r_max <= new_max;
                    end else begin
                        r_pend.cell_full <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_DR_RD: begin
                    r_state <= S_DR_CHK;
                end
                S_DR_CHK: begin
                    if (hit) begin
                        r_state <= S_DR_OUT;
                    end else if (r_dcell == CELL_W'(NUM_CELLS - 1)) begin
                        // Grid exhausted: hold the pointer until the next clear.
                        r_dover <= 1'b1;
                        r_dslot <= '0;
                        r_pend.drain_done <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_dcell <= r_dcell + 1'b1;
                        r_dslot <= '0;
                        r_state <= S_DR_RD;
                    end
                end
                S_DR_OUT: begin
                    r_pend.old_atom_id <= slot_rdata;
                    r_pend.new_index   <= r_didx;
                    r_pend.cell_x <= dx;
                    r_pend.cell_y <= dy;
                    r_pend.cell_z <= dz;
                    r_pend.slot   <= r_dslot;
                    r_didx <= r_didx + 1'b1;
                    if (r_dslot == SLOT_W'(CELL_CAPACITY - 1)) begin
                        r_dslot <= '0;
                        if (r_dcell == CELL_W'(NUM_CELLS - 1)) begin
                            r_dover <= 1'b1;
                        end else begin
                            r_dcell <= r_dcell + 1'b1;
                        end
                    end else begin
                        r_dslot <= r_dslot + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_pend;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* bench/cell_list_binner_test.sv */
// ----------------------------------------------------------------------------
// cell_list_binner_test
// Self-checking bench for the cell list binner: drives clear, bin, drain and
// status items through the queue ports under random idling, predicts every
// result with a local model of the grid and compares each popped result.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_list_binner_test;
    import clb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Predictor of the binner: holds its own copy of counts, slot lists,
    // drain pointer and registers, and a queue of expected results.
    class binner_scoreboard;
        logic [POS_W-1:0] inv_len [3];
        logic [DIM_W-1:0] cells [3];
        logic [THR_W-1:0] threshold;
        int unsigned      cell_pop [NUM_CELLS];
        logic [ID_W-1:0]  slot_ids [NUM_CELLS * CELL_CAPACITY];
        int unsigned      peak;
        int unsigned      drain_cell;
        int unsigned      drain_slot;
        logic [IDX_W-1:0] drain_index;
        bit               drain_exhausted;
        t_res             pending [$];
        int               errors;

        function new();
            for (int a = 0; a < 3; a++) begin
                inv_len[a] = '0;
                cells[a] = 4'd1;
            end
            threshold = 6'd32;
            errors = 0;
            empty_grid();
        endfunction

        function void empty_grid();
            foreach (cell_pop[c]) cell_pop[c] = 0;
            peak = 0;
            drain_cell = 0;
            drain_slot = 0;
            drain_index = '0;
            drain_exhausted = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
            case (idx)
                CFG_INV_X:   inv_len[0] = data;
                CFG_INV_Y:   inv_len[1] = data;
                CFG_INV_Z:   inv_len[2] = data;
                CFG_CELLS_X: cells[0] = data[DIM_W-1:0];
                CFG_CELLS_Y: cells[1] = data[DIM_W-1:0];
                CFG_CELLS_Z: cells[2] = data[DIM_W-1:0];
                CFG_THRESH:  threshold = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned axis_span(int a);
            if (cells[a] == 0) return 1;
            if (cells[a] > GRID_DIM_MAX) return GRID_DIM_MAX;
            return 32'(cells[a]);
        endfunction

        function int unsigned axis_cell(logic [POS_W-1:0] pos, int a);
            logic [2*POS_W-1:0] prod;
            int unsigned        hi;
            prod = (2*POS_W)'(pos) * (2*POS_W)'(inv_len[a]);
            hi = axis_span(a) - 1;
            if ((prod >> POS_W) > hi) return hi;
            return 32'(prod >> POS_W);
        endfunction

        // Work out the result that one accepted item causes.
        function void note_item(t_item it);
            t_res        r;
            int unsigned x, y, z, c, n;
            bit          found;
            r = '0;
            case (it.operation)
                OP_CLEAR: empty_grid();
                OP_BIN: begin
                    x = axis_cell(it.pos_x, 0);
                    y = axis_cell(it.pos_y, 1);
                    z = axis_cell(it.pos_z, 2);
                    c = (x * GRID_DIM_MAX + y) * GRID_DIM_MAX + z;
                    n = cell_pop[c];
                    r.old_atom_id = it.atom_id;
                    r.cell_x = CIDX_W'(x);
                    r.cell_y = CIDX_W'(y);
                    r.cell_z = CIDX_W'(z);
                    if (n >= CELL_CAPACITY) begin
                        r.cell_full = 1'b1;
                    end else begin
                        slot_ids[c * CELL_CAPACITY + n] = it.atom_id;
                        cell_pop[c] = n + 1;
                        r.slot = SLOT_W'(n);
                        if (n + 1 > peak) peak = n + 1;
                    end
                end
                OP_DRAIN: begin
                    found = 0;
                    if (!drain_exhausted) begin
                        c = drain_cell;
                        while (c < NUM_CELLS) begin
                            x = c / (GRID_DIM_MAX * GRID_DIM_MAX);
                            y = (c / GRID_DIM_MAX) % GRID_DIM_MAX;
                            z = c % GRID_DIM_MAX;
                            if (x < axis_span(0) && y < axis_span(1) && z < axis_span(2)
                                    && drain_slot < cell_pop[c]) begin
                                r.old_atom_id = slot_ids[c * CELL_CAPACITY + drain_slot];
                                r.new_index = drain_index;
                                r.cell_x = CIDX_W'(x);
                                r.cell_y = CIDX_W'(y);
                                r.cell_z = CIDX_W'(z);
                                r.slot = SLOT_W'(drain_slot);
                                found = 1;
                                break;
                            end
                            c++;
                            drain_slot = 0;
                        end
                        if (found) begin
                            drain_cell = c;
                            drain_index = drain_index + 1'b1;
                            drain_slot++;
                            if (drain_slot >= CELL_CAPACITY) begin
                                drain_slot = 0;
                                if (drain_cell + 1 >= NUM_CELLS) drain_exhausted = 1;
                                else drain_cell++;
                            end
                        end else begin
                            drain_exhausted = 1;
                            drain_cell = NUM_CELLS - 1;
                            drain_slot = 0;
                        end
                    end
                    r.drain_done = !found;
                end
                default: ;
            endcase
            r.max_count = CNT_W'(peak);
            r.over_threshold = (peak >= threshold);
            pending.push_back(r);
        endfunction

        function void check_result(t_res got);
            t_res exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.old_atom_id !== exp_r.old_atom_id) begin
                $error("old_atom_id exp %0d got %0d", exp_r.old_atom_id, got.old_atom_id);
                errors++;
            end
            if (got.new_index !== exp_r.new_index) begin
                $error("new_index exp %0d got %0d", exp_r.new_index, got.new_index);
                errors++;
            end
            if (got.cell_x !== exp_r.cell_x) begin
                $error("cell_x exp %0d got %0d", exp_r.cell_x, got.cell_x);
                errors++;
            end
            if (got.cell_y !== exp_r.cell_y) begin
                $error("cell_y exp %0d got %0d", exp_r.cell_y, got.cell_y);
                errors++;
            end
            if (got.cell_z !== exp_r.cell_z) begin
                $error("cell_z exp %0d got %0d", exp_r.cell_z, got.cell_z);
                errors++;
            end
            if (got.slot !== exp_r.slot) begin
                $error("slot exp %0d got %0d", exp_r.slot, got.slot);
                errors++;
            end
            if (got.max_count !== exp_r.max_count) begin
                $error("max_count exp %0d got %0d", exp_r.max_count, got.max_count);
                errors++;
            end
            if (got.cell_full !== exp_r.cell_full) begin
                $error("cell_full exp %0d got %0d", exp_r.cell_full, got.cell_full);
                errors++;
            end
            if (got.over_threshold !== exp_r.over_threshold) begin
                $error("over_threshold exp %0d got %0d", exp_r.over_threshold,
                       got.over_threshold);
                errors++;
            end
            if (got.drain_done !== exp_r.drain_done) begin
                $error("drain_done exp %0d got %0d", exp_r.drain_done, got.drain_done);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_item                i_item;
    logic                 empty;
    logic                 pop;
    t_res                 o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [POS_W-1:0]     i_cfg_data;

    binner_scoreboard grid_model;
    bit               calm;       // last part of the run: no idling
    bit               hold_pop;   // receiver held off for a long stretch
    int               hold_cycles;

    cell_list_binner u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Offer one item and hold it until the block takes it; leave push high
    // so back-to-back items need no second assignment in one step.
    task automatic send_item(t_item it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        grid_model.note_item(it);
    endtask

    // Leave valid high so that writes in a row need no second assignment
    // in one step; set_grid drops it after its last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        grid_model.write_reg(idx, data);
    endtask

    // Drop push, wait for every expected result, then let a clear or a
    // drain still in the back end run out before touching registers.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (grid_model.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_grid(int nx, int ny, int nz, logic [POS_W-1:0] ix,
                            logic [POS_W-1:0] iy, logic [POS_W-1:0] iz, int thr);
        write_reg(CFG_INV_X, ix);
        write_reg(CFG_INV_Y, iy);
        write_reg(CFG_INV_Z, iz);
        write_reg(CFG_CELLS_X, POS_W'(nx));
        write_reg(CFG_CELLS_Y, POS_W'(ny));
        write_reg(CFG_CELLS_Z, POS_W'(nz));
        write_reg(CFG_THRESH, POS_W'(thr));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_item(t_op op, logic [ID_W-1:0] id, logic [POS_W-1:0] px,
                                        logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
        t_item it;
        it.operation = op;
        it.atom_id = id;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        return it;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        endcase
    endfunction

    function automatic t_item rand_item(int bin_weight);
        int   pick;
        t_op  op;
        pick = $urandom_range(0, 99);
        if (pick < bin_weight)      op = OP_BIN;
        else if (pick < 97)         op = OP_DRAIN;
        else if (pick < 99)         op = OP_STATUS;
        else                        op = OP_CLEAR;
        return make_item(op, ID_W'($urandom_range(0, ATOM_LIMIT - 1)), rand_pos(),
                         rand_pos(), rand_pos());
    endfunction

    // One phase: clear, a batch of bins crowding a few cells, then mostly
    // drains to walk the pointer through the grid and past its end.
    task automatic run_phase(int count);
        send_item(make_item(OP_CLEAR, '0, '0, '0, '0));
        for (int k = 0; k < count; k++) begin
            send_item(rand_item(k < count / 2 ? 88 : 15));
        end
    endtask

    // Sender side is the main initial block.
    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        calm        = 0;
        hold_pop    = 0;
        grid_model  = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: register defaults give a single cell. Fill it past
        // capacity so the full-cell drop shows, then drain two atoms from it.
        send_item(make_item(OP_STATUS, '1, '1, '1, '1));
        for (int k = 0; k < CELL_CAPACITY + 1; k++)
            send_item(make_item(OP_BIN, ID_W'(k * 97), '1, '0, '1));
        send_item(make_item(OP_DRAIN, '0, '0, '0, '0));
        send_item(make_item(OP_DRAIN, '1, '1, '1, '1));
        settle();

        // Zero cells and oversized cells; full inverse lengths; zero threshold.
        set_grid(0, 15, 9, '1, '1, '1, 0);
        send_item(make_item(OP_CLEAR, '1, '1, '1, '1));
        send_item(make_item(OP_BIN, '1, '1, '1, '1));
        send_item(make_item(OP_BIN, '0, '0, '0, '0));
        send_item(make_item(OP_BIN, 12'h5a5, 24'h800000, 24'hffffff, 24'h000001));
        send_item(make_item(OP_STATUS, '0, '0, '0, '0));
        for (int k = 0; k < 5; k++)
            send_item(make_item(OP_DRAIN, '0, '0, '0, '0));
        // Bin after exhaustion stays hidden until the next clear.
        send_item(make_item(OP_BIN, 12'h123, 24'h400000, 24'h400000, 24'h400000));
        send_item(make_item(OP_DRAIN, '0, '0, '0, '0));
        settle();

        // Random phases over several grid shapes, extremes among them.
        set_grid(8, 8, 8, 24'h000010, 24'h000010, 24'h000010, 4);
        run_phase(120);
        settle();
        set_grid(2, 3, 1, 24'h000004, 24'h000002, '0, 32);
        run_phase(150);

        // Keep the receiver off while items pile up and full rises.
        hold_cycles = 300;
        hold_pop = 1;
        run_phase(60);
        settle();
        set_grid(8, 1, 8, POS_W'($urandom_range(0, 255)), '1,
                 POS_W'($urandom_range(0, 255)), 1);
        run_phase(200);
        settle();
        set_grid($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                 POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                 POS_W'($urandom_range(0, 63)), $urandom_range(0, 32));
        run_phase(250);
        settle();
        set_grid(1, 1, 1, '0, '0, '0, 32);
        run_phase(200);
        calm = 1;
        run_phase(100);
        settle();

        if (grid_model.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver: pops with random stall bursts; one long hold on request.
    initial begin
        int stall;
        pop = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_pop = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 8);
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
                if (pop && !empty) grid_model.check_result(o_result);
            end
        end
    end

    // Overall run limit.
    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/clb_pkg.sv
design/clb_ram.sv
design/clb_front.sv
design/clb_fifo.sv
design/clb_back.sv
design/cell_list_binner.sv
bench/cell_list_binner_test.sv
